/* rtl/fpd_pkg.sv */
// Shared types and constants for the signed fixed point divider.
// Used by every module of the divider; depends on nothing.
`default_nettype none

package fpd_pkg;

   localparam int WORD_W = 32;

   localparam logic [WORD_W-1:0] SAT_POS = 32'h7FFF_FFFF;
   localparam logic [WORD_W-1:0] SAT_NEG = 32'h8000_0000;

   localparam logic ACTION_FIXED = 1'b0;

   typedef struct packed {
      logic dnd_neg;
      logic dsr_neg;
      logic dbz;
   } ctrl_type;

   typedef struct packed {
      logic [WORD_W-1:0] quotient;
      logic              dbz;
      logic              ovf;
   } result_type;

endpackage

`default_nettype wire

/* rtl/fpd_prep.sv */
// Entry stage: operand magnitudes, signs, zero divisor check and fixed point scaling.
// Depends on fpd_pkg.
`default_nettype none

module fpd_prep
   import fpd_pkg::*;
#(
   parameter int FRACTION_BITS = 16
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              advance,
   input  wire logic                              valid_i,
   input  wire logic                              action_i,
   input  wire logic signed [WORD_W-1:0]          dividend_i,
   input  wire logic signed [WORD_W-1:0]          divisor_i,
   output logic                                   valid_o,
   output logic [WORD_W+FRACTION_BITS-1:0]        qd_o,
   output logic [WORD_W-1:0]                      dsr_o,
   output ctrl_type                               ctrl_o
);

   localparam int DW = WORD_W + FRACTION_BITS;

   logic                valid_ff;
   logic [DW-1:0]       qd_ff;
   logic [DW-1:0]       qd_in;
   logic [WORD_W-1:0]   dsr_ff;
   logic [WORD_W-1:0]   dsr_in;
   ctrl_type            ctrl_ff;
   ctrl_type            ctrl_in;
   logic [WORD_W-1:0]   dnd_raw;
   logic [WORD_W-1:0]   dsr_raw;
   logic [WORD_W-1:0]   dnd_mag;

   always_comb begin
      dnd_raw = WORD_W'(unsigned'(dividend_i));
      dsr_raw = WORD_W'(unsigned'(divisor_i));
      ctrl_in.dnd_neg = dnd_raw[WORD_W-1];
      ctrl_in.dsr_neg = dsr_raw[WORD_W-1];
      ctrl_in.dbz     = (dsr_raw == '0);
      dnd_mag = ctrl_in.dnd_neg ? WORD_W'(~dnd_raw + 1'b1) : dnd_raw;
      dsr_in  = ctrl_in.dsr_neg ? WORD_W'(~dsr_raw + 1'b1) : dsr_raw;
      if (action_i == ACTION_FIXED) begin
         qd_in = DW'(dnd_mag) << FRACTION_BITS;
      end else begin
         qd_in = DW'(dnd_mag);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_i;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         qd_ff   <= qd_in;
         dsr_ff  <= dsr_in;
         ctrl_ff <= ctrl_in;
      end
   end

   assign valid_o = valid_ff;
   assign qd_o    = qd_ff;
   assign dsr_o   = dsr_ff;
   assign ctrl_o  = ctrl_ff;

endmodule

`default_nettype wire

/* rtl/fpd_step.sv */
// One restoring division step: yields one quotient bit per register stage.
// Depends on fpd_pkg.
`default_nettype none

module fpd_step
   import fpd_pkg::*;
#(
   parameter int FRACTION_BITS = 16
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              advance,
   input  wire logic                              valid_i,
   input  wire logic [WORD_W-1:0]                 rem_i,
   input  wire logic [WORD_W+FRACTION_BITS-1:0]   qd_i,
   input  wire logic [WORD_W-1:0]                 dsr_i,
   input  wire ctrl_type                          ctrl_i,
   output logic                                   valid_o,
   output logic [WORD_W-1:0]                      rem_o,
   output logic [WORD_W+FRACTION_BITS-1:0]        qd_o,
   output logic [WORD_W-1:0]                      dsr_o,
   output ctrl_type                               ctrl_o
);

   localparam int DW = WORD_W + FRACTION_BITS;

   logic                valid_ff;
   logic [WORD_W-1:0]   rem_ff;
   logic [WORD_W-1:0]   rem_in;
   logic [DW-1:0]       qd_ff;
   logic [DW-1:0]       qd_in;
   logic [WORD_W-1:0]   dsr_ff;
   ctrl_type            ctrl_ff;
   logic [WORD_W+1:0]   diff;
   logic                take;

   always_comb begin
      diff = {1'b0, rem_i, qd_i[DW-1]} - {2'b00, dsr_i};
      take = !diff[WORD_W+1];
      if (take) begin
         rem_in = diff[WORD_W-1:0];
      end else begin
         rem_in = {rem_i[WORD_W-2:0], qd_i[DW-1]};
      end
      qd_in = {qd_i[DW-2:0], take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_i;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff  <= rem_in;
         qd_ff   <= qd_in;
         dsr_ff  <= dsr_i;
         ctrl_ff <= ctrl_i;
      end
   end

   assign valid_o = valid_ff;
   assign rem_o   = rem_ff;
   assign qd_o    = qd_ff;
   assign dsr_o   = dsr_ff;
   assign ctrl_o  = ctrl_ff;

endmodule

`default_nettype wire

/* rtl/fpd_post.sv */
// Result stage: sign, saturation and overflow, then a two-entry output buffer.
// Depends on fpd_pkg; its free slot count drives the pipeline advance.
`default_nettype none

module fpd_post
   import fpd_pkg::*;
#(
   parameter int FRACTION_BITS = 16
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              valid_i,
   input  wire logic [WORD_W+FRACTION_BITS-1:0]   qd_i,
   input  wire ctrl_type                          ctrl_i,
   input  wire logic                              rsp_stall,
   output logic                                   advance,
   output logic                                   rsp_valid,
   output logic signed [WORD_W-1:0]               rsp_quotient,
   output logic                                   rsp_divide_by_zero,
   output logic                                   rsp_overflow
);

   localparam int DW = WORD_W + FRACTION_BITS;

   result_type    res;
   logic          qneg;
   logic          push;
   logic          pop;
   logic          head_valid_ff;
   logic          head_valid_in;
   logic          skid_valid_ff;
   logic          skid_valid_in;
   result_type    head_ff;
   result_type    head_in;
   result_type    skid_ff;
   result_type    skid_in;

   always_comb begin
      qneg = (ctrl_i.dnd_neg != ctrl_i.dsr_neg) && (qd_i != '0);
      if (ctrl_i.dbz) begin
         res.quotient = ctrl_i.dnd_neg ? SAT_NEG : SAT_POS;
         res.dbz      = 1'b1;
         res.ovf      = 1'b0;
      end else if (qneg) begin
         res.quotient = WORD_W'(~qd_i[WORD_W-1:0] + 1'b1);
         res.dbz      = 1'b0;
         res.ovf      = (qd_i > DW'(SAT_NEG));
      end else begin
         res.quotient = qd_i[WORD_W-1:0];
         res.dbz      = 1'b0;
         res.ovf      = (qd_i > DW'(SAT_POS));
      end
   end

   assign advance = !skid_valid_ff;
   assign push    = advance && valid_i;
   assign pop     = head_valid_ff && !rsp_stall;

   always_comb begin
      head_valid_in = head_valid_ff;
      skid_valid_in = skid_valid_ff;
      head_in       = head_ff;
      skid_in       = skid_ff;
      if (pop) begin
         if (skid_valid_ff) begin
            head_in       = skid_ff;
            skid_valid_in = push;
            skid_in       = res;
         end else begin
            head_valid_in = push;
            head_in       = res;
         end
      end else if (push) begin
         if (head_valid_ff) begin
            skid_valid_in = 1'b1;
            skid_in       = res;
         end else begin
            head_valid_in = 1'b1;
            head_in       = res;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         head_valid_ff <= head_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid          = head_valid_ff;
   assign rsp_quotient       = $signed(head_ff.quotient);
   assign rsp_divide_by_zero = head_ff.dbz;
   assign rsp_overflow       = head_ff.ovf;

endmodule

`default_nettype wire

/* rtl/fixed_point_divider_top.sv */
// Top level of the pipelined signed 16.16 fixed point divider.
// Depends on fpd_pkg, fpd_prep, fpd_step and fpd_post.
//
//   Channel | Direction | Handshake          | Beat contents
//   req     | in        | req_valid/req_stall | action, dividend, divisor
//   rsp     | out       | rsp_valid/rsp_stall | quotient, divide_by_zero, overflow
//
// A new beat can be accepted every cycle while req_stall is low; one result
// beat leaves per request beat. The pipeline has one entry stage, one restoring
// step stage per quotient bit, and the output register.
// Reset clears only the valid bits; the datapath needs no clearing.
// A two-entry output buffer decouples the sides; req_stall rises only once it is full.
`default_nettype none

module fixed_point_divider_top
   import fpd_pkg::*;
#(
   parameter int FRACTION_BITS = 16
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire logic                      req_action,
   input  wire logic signed [WORD_W-1:0]  req_dividend,
   input  wire logic signed [WORD_W-1:0]  req_divisor,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output logic signed [WORD_W-1:0]       rsp_quotient,
   output logic                           rsp_divide_by_zero,
   output logic                           rsp_overflow
);

   localparam int DW = WORD_W + FRACTION_BITS;

   logic                advance;
   logic                stg_valid [DW+1];
   logic [WORD_W-1:0]   stg_rem   [DW+1];
   logic [DW-1:0]       stg_qd    [DW+1];
   logic [WORD_W-1:0]   stg_dsr   [DW+1];
   ctrl_type            stg_ctrl  [DW+1];

   assign req_stall  = !advance;
   assign stg_rem[0] = '0;

   fpd_prep #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_prep (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .valid_i    (req_valid),
      .action_i   (req_action),
      .dividend_i (req_dividend),
      .divisor_i  (req_divisor),
      .valid_o    (stg_valid[0]),
      .qd_o       (stg_qd[0]),
      .dsr_o      (stg_dsr[0]),
      .ctrl_o     (stg_ctrl[0])
   );

   for (genvar i = 0; i < DW; i++) begin : g_step
      fpd_step #(
         .FRACTION_BITS (FRACTION_BITS)
      ) u_step (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .valid_i (stg_valid[i]),
         .rem_i   (stg_rem[i]),
         .qd_i    (stg_qd[i]),
         .dsr_i   (stg_dsr[i]),
         .ctrl_i  (stg_ctrl[i]),
         .valid_o (stg_valid[i+1]),
         .rem_o   (stg_rem[i+1]),
         .qd_o    (stg_qd[i+1]),
         .dsr_o   (stg_dsr[i+1]),
         .ctrl_o  (stg_ctrl[i+1])
      );
   end

   fpd_post #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_post (
      .clock              (clock),
      .reset              (reset),
      .valid_i            (stg_valid[DW]),
      .qd_i               (stg_qd[DW]),
      .ctrl_i             (stg_ctrl[DW]),
      .rsp_stall          (rsp_stall),
      .advance            (advance),
      .rsp_valid          (rsp_valid),
      .rsp_quotient       (rsp_quotient),
      .rsp_divide_by_zero (rsp_divide_by_zero),
      .rsp_overflow       (rsp_overflow)
   );

endmodule

`default_nettype wire
